@@ sv/ihq_pkg.sv @@
package ihq_pkg;

  // request codes
  localparam logic [3:0] REQ_INSERT = 4'd0;
  localparam logic [3:0] REQ_POP    = 4'd1;
  localparam logic [3:0] REQ_REMOVE = 4'd2;
  localparam logic [3:0] REQ_CHANGE = 4'd3;
  localparam logic [3:0] REQ_QUERY  = 4'd4;
  localparam logic [3:0] REQ_APPEND = 4'd5;
  localparam logic [3:0] REQ_BUILD  = 4'd6;
  localparam logic [3:0] REQ_READ   = 4'd7;
  localparam logic [3:0] REQ_WRITE  = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] item_key;
    logic [31:0] item_payload;
    logic [10:0] heap_pos;
    logic [10:0] item_id;
  } req_t;

  typedef struct packed {
    logic [31:0] out_key;
    logic [31:0] out_payload;
    logic [10:0] out_id;
    logic [10:0] out_pos;
    logic [10:0] count;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_PLACE_RD,
    OP_PLACE_WR,
    OP_SU_RD,
    OP_SU_KEY,
    OP_SU_MOVE,
    OP_SD_RD,
    OP_SD_KEY,
    OP_SD_MOVE,
    OP_FINAL,
    OP_TK_RD,
    OP_TK_WR1,
    OP_TK_WR2,
    OP_TK_PKEY,
    OP_SET_K,
    OP_CH_RD,
    OP_CH_KEY,
    OP_CH_WR,
    OP_Q_RD,
    OP_Q_OK,
    OP_B_INIT,
    OP_B_RD,
    OP_B_KEY,
    OP_B_SET,
    OP_B_NEXT,
    OP_RD_RD,
    OP_RD_CAP,
    OP_WR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] req_type;
    logic       full;
    logic       empty;
    logic       pos_bad;
    logic       id_bad;
    logic       k_gt1;
    logic       su_move;
    logic       sd_more;
    logic       sd_move;
    logic       tk_repair;
    logic       tk_up;
    logic       ch_down;
    logic       q_bad;
    logic       b_more;
    logic       out_free;
  } dp_flags_t;

endpackage

@@ sv/ihq_datapath.sv @@
module ihq_datapath import ihq_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  req_t      req,
  input  dp_cmd_t   cmd,
  output dp_flags_t flags,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_t      rsp
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int KB = KEY_BITS;

  logic [KB-1:0] ks_mem [CAPACITY+1];
  logic [31:0]   ps_mem [CAPACITY+1];
  logic [PW-1:0] ho_mem [CAPACITY+1];
  logic [PW-1:0] ip_mem [CAPACITY+1];

  req_t          rq;
  logic [PW-1:0] cnt, filled, p, k, c, id, pid, cid0, cid1, gone, bk;
  logic [KB-1:0] ikey, res_key;
  logic [31:0]   res_pay;
  logic [PW-1:0] res_id, res_pos;
  logic [1:0]    res_st;
  rsp_t          rsp_q;
  logic          rsp_valid_q;

  logic [PW-1:0] ho_rd0, ho_rd1, ip_rd;
  logic [KB-1:0] ks_rd0, ks_rd1;
  logic [31:0]   ps_rd;

  logic [PW-1:0] ho_ra0, ho_ra1, ks_ra0, ks_ra1, ps_ra, ip_ra;
  logic          ho_we, ip_we, ks_we, ps_we;
  logic [PW-1:0] ho_wa, ho_wd, ip_wa, ip_wd, ks_wa, ps_wa;
  logic [KB-1:0] ks_wd;
  logic [31:0]   ps_wd;

  logic [63:0]   key_ext, rk_ext;
  logic [KB-1:0] newkey;
  logic [PW-1:0] iid, pos_new, newid, c_n, c1, cid, cpos;
  logic [PW:0]   c_w;
  logic [KB-1:0] ck;
  logic          sel1;

  assign key_ext = {32'b0, rq.item_key};
  assign newkey  = key_ext[KB-1:0];
  assign rk_ext  = 64'(res_key);
  assign iid     = PW'(rq.item_id);
  assign pos_new = cnt + PW'(1);
  assign newid   = (pos_new <= filled) ? ho_rd0 : pos_new;
  assign c_w     = {1'b0, k} << 1;
  assign c_n     = c_w[PW-1:0];
  assign c1      = c + PW'(1);
  assign sel1    = (c < cnt) && (ks_rd1 < ks_rd0);
  assign cid     = sel1 ? cid1 : cid0;
  assign ck      = sel1 ? ks_rd1 : ks_rd0;
  assign cpos    = sel1 ? c1 : c;

  always_comb begin
    flags.req_type  = rq.req_type;
    flags.full      = (cnt == PW'(CAPACITY));
    flags.empty     = (cnt == '0);
    flags.pos_bad   = (rq.heap_pos == '0) || (32'(rq.heap_pos) > 32'(cnt));
    flags.id_bad    = (rq.item_id == '0) || (32'(rq.item_id) > 32'(filled));
    flags.k_gt1     = (k > PW'(1));
    flags.su_move   = !(ks_rd0 < ikey);
    flags.sd_more   = (k <= (cnt >> 1));
    flags.sd_move   = (ck < ikey);
    flags.tk_repair = (p <= cnt);
    flags.tk_up     = (p > PW'(1)) && !(ks_rd0 < ikey);
    flags.ch_down   = (ks_rd0 < newkey);
    flags.q_bad     = (ip_rd > cnt);
    flags.b_more    = (bk != '0);
    flags.out_free  = !rsp_valid_q || rsp_ready;
  end

  // memory port muxing
  always_comb begin
    ho_ra0 = p;
    ho_ra1 = cnt;
    ks_ra0 = iid;
    ks_ra1 = iid;
    ps_ra  = iid;
    ip_ra  = iid;
    ho_we  = 1'b0;
    ip_we  = 1'b0;
    ks_we  = 1'b0;
    ps_we  = 1'b0;
    ho_wa  = k;
    ho_wd  = id;
    ip_wa  = id;
    ip_wd  = k;
    ks_wa  = iid;
    ks_wd  = newkey;
    ps_wa  = iid;
    ps_wd  = rq.item_payload;
    case (cmd.op)
      OP_PLACE_RD: ho_ra0 = pos_new;
      OP_PLACE_WR: begin
        ho_we = 1'b1; ho_wa = pos_new; ho_wd = newid;
        ip_we = 1'b1; ip_wa = newid;   ip_wd = pos_new;
        ks_we = 1'b1; ks_wa = newid;
        ps_we = 1'b1; ps_wa = newid;
      end
      OP_SU_RD:  ho_ra0 = k >> 1;
      OP_SU_KEY: ks_ra0 = ho_rd0;
      OP_SU_MOVE: begin
        ho_we = 1'b1; ho_wd = pid;
        ip_we = 1'b1; ip_wa = pid;
      end
      OP_SD_RD: begin
        ho_ra0 = c_n;
        ho_ra1 = (c_n < cnt) ? c_n + PW'(1) : c_n;
      end
      OP_SD_KEY: begin
        ks_ra0 = ho_rd0;
        ks_ra1 = ho_rd1;
      end
      OP_SD_MOVE: begin
        ho_we = 1'b1; ho_wd = cid;
        ip_we = 1'b1; ip_wa = cid;
      end
      OP_FINAL: begin
        ho_we = 1'b1;
        ip_we = 1'b1;
      end
      OP_TK_RD: begin
        ho_ra0 = p;
        ho_ra1 = cnt;
      end
      OP_TK_WR1: begin
        ho_we = 1'b1; ho_wa = p; ho_wd = ho_rd1;
        ip_we = 1'b1; ip_wa = ho_rd1; ip_wd = p;
        ks_ra0 = ho_rd0;
        ks_ra1 = ho_rd1;
        ps_ra  = ho_rd0;
      end
      OP_TK_WR2: begin
        ho_we = 1'b1; ho_wa = cnt; ho_wd = gone;
        ip_we = 1'b1; ip_wa = gone; ip_wd = cnt;
        ho_ra0 = p >> 1;
      end
      OP_TK_PKEY: ks_ra0 = ho_rd0;
      OP_CH_RD:   ho_ra0 = p;
      OP_CH_KEY:  ks_ra0 = ho_rd0;
      OP_CH_WR: begin
        ks_we = 1'b1; ks_wa = id;
        ps_we = 1'b1; ps_wa = id;
      end
      OP_B_RD:  ho_ra0 = bk;
      OP_B_KEY: ks_ra0 = ho_rd0;
      OP_WR: begin
        ks_we = 1'b1;
        ps_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ho_we) ho_mem[ho_wa] <= ho_wd;
    if (ip_we) ip_mem[ip_wa] <= ip_wd;
    if (ks_we) ks_mem[ks_wa] <= ks_wd;
    if (ps_we) ps_mem[ps_wa] <= ps_wd;
    ho_rd0 <= ho_mem[ho_ra0];
    ho_rd1 <= ho_mem[ho_ra1];
    ip_rd  <= ip_mem[ip_ra];
    ks_rd0 <= ks_mem[ks_ra0];
    ks_rd1 <= ks_mem[ks_ra1];
    ps_rd  <= ps_mem[ps_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      filled      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) rsp_valid_q <= 1'b1;
      else if (rsp_ready)    rsp_valid_q <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          rq      <= req;
          p       <= (req.req_type == REQ_POP) ? PW'(1) : PW'(req.heap_pos);
          res_key <= '0;
          res_pay <= '0;
          res_id  <= '0;
          res_pos <= '0;
          res_st  <= ST_OK;
        end
        OP_ERR: res_st <= cmd.st;
        OP_PLACE_WR: begin
          cnt    <= pos_new;
          if (pos_new > filled) filled <= pos_new;
          res_id <= newid;
          id     <= newid;
          ikey   <= newkey;
          k      <= pos_new;
        end
        OP_SU_KEY:  pid <= ho_rd0;
        OP_SU_MOVE: k <= k >> 1;
        OP_SD_RD:   c <= c_n;
        OP_SD_KEY: begin
          cid0 <= ho_rd0;
          cid1 <= ho_rd1;
        end
        OP_SD_MOVE: k <= cpos;
        OP_TK_WR1: begin
          gone <= ho_rd0;
          id   <= ho_rd1;
        end
        OP_TK_WR2: begin
          cnt     <= cnt - PW'(1);
          res_key <= ks_rd0;
          res_pay <= ps_rd;
          res_id  <= gone;
          ikey    <= ks_rd1;
        end
        OP_SET_K:  k <= p;
        OP_CH_KEY: id <= ho_rd0;
        OP_CH_WR: begin
          ikey    <= newkey;
          k       <= p;
          res_key <= newkey;
          res_pay <= rq.item_payload;
          res_id  <= id;
        end
        OP_Q_OK:   res_pos <= ip_rd;
        OP_B_INIT: bk <= cnt >> 1;
        OP_B_RD:   k <= bk;
        OP_B_KEY:  id <= ho_rd0;
        OP_B_SET:  ikey <= ks_rd0;
        OP_B_NEXT: bk <= bk - PW'(1);
        OP_RD_CAP: begin
          res_key <= ks_rd0;
          res_pay <= ps_rd;
        end
        OP_EMIT: begin
          rsp_q.out_key     <= rk_ext[31:0];
          rsp_q.out_payload <= res_pay;
          rsp_q.out_id      <= 11'(res_id);
          rsp_q.out_pos     <= 11'(res_pos);
          rsp_q.count       <= 11'(cnt);
          rsp_q.status      <= res_st;
        end
        default: ;
      endcase
    end
  end

  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  a_cnt_le_filled: assert property (@(posedge clk) disable iff (rst)
    (cnt <= filled) && (32'(filled) <= CAPACITY))
    else $error("count above high-water mark or capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> (!rsp_valid_q || rsp_ready))
    else $error("result overwritten before transfer");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cnt == $past(cnt)) || (cnt == $past(cnt) + PW'(1)) ||
             (cnt == $past(cnt) - PW'(1)))
    else $error("count moved by more than one");

endmodule

@@ sv/ihq_ctrl.sv @@
module ihq_ctrl import ihq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  dp_flags_t flags,
  output dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_PLACE_RD, S_PLACE_WR,
    S_SU_RD, S_SU_KEY, S_SU_CMP, S_SD_RD, S_SD_KEY, S_SD_CMP,
    S_TK_RD, S_TK_WR1, S_TK_WR2, S_TK_PKEY, S_TK_DEC,
    S_CH_RD, S_CH_KEY, S_CH_WR, S_Q_RD, S_Q_CHK,
    S_B_INIT, S_B_TOP, S_B_KEY, S_B_SET, S_B_NEXT,
    S_RD_RD, S_RD_CAP, S_EMIT
  } state_t;

  state_t state, state_next, done_state;

  assign req_ready  = (state == S_IDLE);
  assign done_state = (flags.req_type == REQ_BUILD) ? S_B_NEXT : S_EMIT;

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.st     = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) begin
        cmd.op = OP_LOAD; state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_EMIT;
        case (flags.req_type)
          REQ_INSERT, REQ_APPEND:
            if (flags.full) begin cmd.op = OP_ERR; cmd.st = ST_FULL; end
            else state_next = S_PLACE_RD;
          REQ_POP:
            if (flags.empty) begin cmd.op = OP_ERR; cmd.st = ST_EMPTY; end
            else state_next = S_TK_RD;
          REQ_REMOVE:
            if (flags.pos_bad) begin cmd.op = OP_ERR; cmd.st = ST_BAD; end
            else state_next = S_TK_RD;
          REQ_CHANGE:
            if (flags.pos_bad) begin cmd.op = OP_ERR; cmd.st = ST_BAD; end
            else state_next = S_CH_RD;
          REQ_QUERY:
            if (flags.id_bad) begin cmd.op = OP_ERR; cmd.st = ST_BAD; end
            else state_next = S_Q_RD;
          REQ_BUILD: state_next = S_B_INIT;
          REQ_READ:
            if (flags.id_bad) begin cmd.op = OP_ERR; cmd.st = ST_BAD; end
            else state_next = S_RD_RD;
          REQ_WRITE:
            if (flags.id_bad) begin cmd.op = OP_ERR; cmd.st = ST_BAD; end
            else cmd.op = OP_WR;
          default: begin cmd.op = OP_ERR; cmd.st = ST_BAD; end
        endcase
      end
      S_PLACE_RD: begin cmd.op = OP_PLACE_RD; state_next = S_PLACE_WR; end
      S_PLACE_WR: begin
        cmd.op     = OP_PLACE_WR;
        state_next = (flags.req_type == REQ_INSERT) ? S_SU_RD : S_EMIT;
      end
      S_SU_RD:
        if (flags.k_gt1) begin cmd.op = OP_SU_RD; state_next = S_SU_KEY; end
        else begin cmd.op = OP_FINAL; state_next = done_state; end
      S_SU_KEY: begin cmd.op = OP_SU_KEY; state_next = S_SU_CMP; end
      S_SU_CMP:
        if (flags.su_move) begin cmd.op = OP_SU_MOVE; state_next = S_SU_RD; end
        else begin cmd.op = OP_FINAL; state_next = done_state; end
      S_SD_RD:
        if (flags.sd_more) begin cmd.op = OP_SD_RD; state_next = S_SD_KEY; end
        else begin cmd.op = OP_FINAL; state_next = done_state; end
      S_SD_KEY: begin cmd.op = OP_SD_KEY; state_next = S_SD_CMP; end
      S_SD_CMP:
        if (flags.sd_move) begin cmd.op = OP_SD_MOVE; state_next = S_SD_RD; end
        else begin cmd.op = OP_FINAL; state_next = done_state; end
      S_TK_RD:   begin cmd.op = OP_TK_RD;   state_next = S_TK_WR1; end
      S_TK_WR1:  begin cmd.op = OP_TK_WR1;  state_next = S_TK_WR2; end
      S_TK_WR2:  begin cmd.op = OP_TK_WR2;  state_next = S_TK_PKEY; end
      S_TK_PKEY: begin cmd.op = OP_TK_PKEY; state_next = S_TK_DEC; end
      S_TK_DEC:
        if (!flags.tk_repair) state_next = S_EMIT;
        else begin
          cmd.op     = OP_SET_K;
          state_next = flags.tk_up ? S_SU_RD : S_SD_RD;
        end
      S_CH_RD:  begin cmd.op = OP_CH_RD;  state_next = S_CH_KEY; end
      S_CH_KEY: begin cmd.op = OP_CH_KEY; state_next = S_CH_WR; end
      S_CH_WR: begin
        cmd.op     = OP_CH_WR;
        state_next = flags.ch_down ? S_SD_RD : S_SU_RD;
      end
      S_Q_RD: begin cmd.op = OP_Q_RD; state_next = S_Q_CHK; end
      S_Q_CHK: begin
        state_next = S_EMIT;
        if (flags.q_bad) begin cmd.op = OP_ERR; cmd.st = ST_BAD; end
        else cmd.op = OP_Q_OK;
      end
      S_B_INIT: begin cmd.op = OP_B_INIT; state_next = S_B_TOP; end
      S_B_TOP:
        if (flags.b_more) begin cmd.op = OP_B_RD; state_next = S_B_KEY; end
        else state_next = S_EMIT;
      S_B_KEY:  begin cmd.op = OP_B_KEY;  state_next = S_B_SET; end
      S_B_SET:  begin cmd.op = OP_B_SET;  state_next = S_SD_RD; end
      S_B_NEXT: begin cmd.op = OP_B_NEXT; state_next = S_B_TOP; end
      S_RD_RD:  begin cmd.op = OP_RD_RD;  state_next = S_RD_CAP; end
      S_RD_CAP: begin cmd.op = OP_RD_CAP; state_next = S_EMIT; end
      S_EMIT:
        if (flags.out_free) begin cmd.op = OP_EMIT; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ sv/indexed_min_heap_queue_unit.sv @@
// One request at a time: req_ready is high only while idle, so the next request is taken
//   only after the previous result has gone into a free result register. Insert sifts up,
//   change and pop/remove sift up or down (pop/remove of the last item: no sift), and build
//   sifts down each internal node.
// Reset (rst, synchronous): item count, high-water mark and pending result cleared; RAMs kept.
module indexed_min_heap_queue_unit import ihq_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Command/status link between the sequencer and the heap RAM datapath.
  dp_cmd_t   cmd;
  dp_flags_t flags;

  // Sequencer: decodes the request, steps the sift loops, waits for a free
  // result register before issuing the result transfer.
  ihq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // Datapath: key/payload/order/position RAMs, sift registers and the
  // result register that holds the finished transfer.
  ihq_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .flags     (flags),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ test/indexed_min_heap_queue_unit_tb.sv @@
module indexed_min_heap_queue_unit_tb;
  import ihq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;
  // cycles with no transfer on either side before the run is abandoned;
  // a build at full size plus the long receiver hold stays well below this
  localparam int IDLE_LIMIT = 200000;
  localparam int RX_HOLD = 400;

  // Shadow of the indexed heap: predicts the response for every accepted request
  class heap_scoreboard;
    logic [31:0] keys[CAP+1];
    logic [31:0] pays[CAP+1];
    int order[CAP+1];
    int where_at[CAP+1];
    int cnt;
    int hw;
    rsp_t waiting[$];
    int fails;
    int checked;
    int hit_full;
    int max_cnt;

    function new();
      cnt = 0;
      hw = 0;
      fails = 0;
      checked = 0;
      hit_full = 0;
      max_cnt = 0;
    endfunction

    function void lift(int k);
      int id;
      id = order[k];
      while (k > 1 && !(keys[order[k/2]] < keys[id])) begin
        order[k] = order[k/2];
        where_at[order[k]] = k;
        k = k / 2;
      end
      order[k] = id;
      where_at[id] = k;
    endfunction

    function void sink(int k);
      int id;
      int c;
      id = order[k];
      while (k <= cnt / 2) begin
        c = 2 * k;
        if (c < cnt && keys[order[c+1]] < keys[order[c]]) c++;
        if (!(keys[order[c]] < keys[id])) break;
        order[k] = order[c];
        where_at[order[k]] = k;
        k = c;
      end
      order[k] = id;
      where_at[id] = k;
    endfunction

    function int take_at(int k);
      int gone;
      int moved;
      gone = order[k];
      moved = order[cnt];
      order[k] = moved;
      where_at[moved] = k;
      order[cnt] = gone;
      where_at[gone] = cnt;
      cnt--;
      if (k <= cnt) begin
        if (k > 1 && !(keys[order[k/2]] < keys[order[k]])) lift(k);
        else sink(k);
      end
      return gone;
    endfunction

    function int place(logic [31:0] key, logic [31:0] pay);
      int p;
      int id;
      p = cnt + 1;
      id = (p <= hw) ? order[p] : p;
      if (p > hw) hw = p;
      keys[id] = key;
      pays[id] = pay;
      order[p] = id;
      where_at[id] = p;
      cnt = p;
      return id;
    endfunction

    function rsp_t step(req_t r);
      rsp_t o;
      int id;
      int p;
      int iid;
      logic [31:0] prev;
      o = '0;
      o.status = ST_OK;
      p = r.heap_pos;
      iid = r.item_id;
      case (r.req_type)
        REQ_INSERT, REQ_APPEND: begin
          if (cnt >= CAP) begin
            o.status = ST_FULL;
            hit_full++;
          end else begin
            id = place(r.item_key, r.item_payload);
            if (r.req_type == REQ_INSERT) lift(cnt);
            o.out_id = 11'(id);
          end
        end
        REQ_POP, REQ_REMOVE: begin
          if (r.req_type == REQ_POP && cnt == 0) o.status = ST_EMPTY;
          else if (r.req_type == REQ_REMOVE && (p == 0 || p > cnt)) o.status = ST_BAD;
          else begin
            if (r.req_type == REQ_POP) p = 1;
            id = take_at(p);
            o.out_key = keys[id];
            o.out_payload = pays[id];
            o.out_id = 11'(id);
          end
        end
        REQ_CHANGE: begin
          if (p == 0 || p > cnt) o.status = ST_BAD;
          else begin
            id = order[p];
            prev = keys[id];
            keys[id] = r.item_key;
            pays[id] = r.item_payload;
            if (prev < keys[id]) sink(p);
            else lift(p);
            o.out_key = keys[id];
            o.out_payload = r.item_payload;
            o.out_id = 11'(id);
          end
        end
        REQ_QUERY: begin
          if (iid == 0 || iid > hw || where_at[iid] > cnt) o.status = ST_BAD;
          else o.out_pos = 11'(where_at[iid]);
        end
        REQ_BUILD: begin
          for (int k = cnt / 2; k >= 1; k--) sink(k);
        end
        REQ_READ: begin
          if (iid == 0 || iid > hw) o.status = ST_BAD;
          else begin
            o.out_key = keys[iid];
            o.out_payload = pays[iid];
          end
        end
        REQ_WRITE: begin
          if (iid == 0 || iid > hw) o.status = ST_BAD;
          else begin
            keys[iid] = r.item_key;
            pays[iid] = r.item_payload;
          end
        end
        default: o.status = ST_BAD;
      endcase
      o.count = 11'(cnt);
      if (cnt > max_cnt) max_cnt = cnt;
      return o;
    endfunction

    function void note(req_t r);
      waiting.push_back(step(r));
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fails++;
    endtask

    task check(rsp_t got);
      rsp_t want;
      if (waiting.size() == 0) begin
        report("unexpected response", 64'(got), 0);
      end else begin
        want = waiting.pop_front();
        checked++;
        if (got.out_key !== want.out_key) report("out_key", got.out_key, want.out_key);
        if (got.out_payload !== want.out_payload)
          report("out_payload", got.out_payload, want.out_payload);
        if (got.out_id !== want.out_id) report("out_id", got.out_id, want.out_id);
        if (got.out_pos !== want.out_pos) report("out_pos", got.out_pos, want.out_pos);
        if (got.count !== want.count) report("count", got.count, want.count);
        if (got.status !== want.status) report("status", got.status, want.status);
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  heap_scoreboard sb;
  bit stim_done;
  bit rx_held;
  int rx_count;
  int idle_cycles;
  int sent;

  indexed_min_heap_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long pause.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function req_t make_req(logic [3:0] t, logic [31:0] key, logic [31:0] pay,
                          logic [10:0] pos, logic [10:0] id);
    req_t r;
    r.req_type = t;
    r.item_key = key;
    r.item_payload = pay;
    r.heap_pos = pos;
    r.item_id = id;
    return r;
  endfunction

  // Keys: full range half the time, a tiny range otherwise so that ties occur.
  function logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'hFFFF_FFFF;
    if (r == 1) return 32'h0;
    if (r < 10) return $urandom;
    return $urandom_range(0, 15);
  endfunction

  // Off-range positions and ids: zero, just past the end, and wide bit patterns.
  function logic [10:0] pick_bad(int lim);
    case ($urandom_range(0, 4))
      0: return 11'd0;
      1: return 11'(lim + 1);
      2: return 11'd2047;
      3: return 11'd1024;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  // mode 0: small heap, mode 1: grow toward full, mode 2: mixed at large size
  function req_t rand_req(int mode);
    req_t r;
    int w;
    int add_w;
    logic [3:0] t;
    r = make_req(REQ_INSERT, pick_key(), $urandom, 11'd0, 11'd0);
    r.heap_pos = (sb.cnt > 0) ? 11'($urandom_range(1, sb.cnt)) : 11'd1;
    r.item_id = (sb.hw > 0) ? 11'($urandom_range(1, sb.hw)) : 11'd1;
    w = $urandom_range(0, 99);
    if (w < 6 && mode != 1) begin
      // noise: random codes, some unknown, and off-range operands
      r.req_type = $urandom_range(0, 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      r.heap_pos = pick_bad(sb.cnt);
      r.item_id = pick_bad(sb.hw);
      return r;
    end
    if (mode == 1) add_w = 100;
    else if (mode == 2) add_w = 20;
    else add_w = (sb.cnt > 20) ? 15 : 45;
    w = $urandom_range(0, 99);
    if (w < add_w) t = $urandom_range(0, 1) ? REQ_INSERT : REQ_APPEND;
    else begin
      case ($urandom_range(0, 13))
        0, 1, 2: t = REQ_POP;
        3, 4: t = REQ_REMOVE;
        5, 6: t = REQ_CHANGE;
        7, 8: t = REQ_QUERY;
        9: t = REQ_BUILD;
        10, 11: t = REQ_READ;
        default: t = REQ_WRITE;
      endcase
      if (mode == 1 && t == REQ_BUILD) t = REQ_READ;
    end
    r.req_type = t;
    return r;
  endfunction

  task send(req_t r);
    int n;
    n = pick_gap();
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note(r);
    sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold once traffic is flowing so the
  // block backs up and the sender sees req_ready low.
  initial begin
    int n;
    rsp_ready = 1'b0;
    rx_held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!rx_held && rx_count >= 60) begin
        rx_held = 1'b1;
        rsp_ready <= 1'b0;
        for (int c = 0; c < RX_HOLD; c++) @(negedge clk);
      end
      n = pick_gap();
      if ($urandom_range(0, 3) == 0 && n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check(rsp);
      rx_count++;
    end
  end

  // Watchdog on transfers in either direction.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("indexed_min_heap_queue_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    req_t dir[$];
    sb = new();
    stim_done = 1'b0;
    rx_count = 0;
    sent = 0;
    idle_cycles = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty-heap errors, unknown codes, then a small heap with ties
    dir.push_back(make_req(REQ_READ, 0, 0, 0, 11'd1));
    dir.push_back(make_req(REQ_POP, 0, 0, 0, 0));
    dir.push_back(make_req(REQ_REMOVE, 0, 0, 11'd1, 0));
    dir.push_back(make_req(REQ_CHANGE, 0, 0, 11'd2047, 0));
    dir.push_back(make_req(REQ_QUERY, 0, 0, 0, 11'd2047));
    dir.push_back(make_req(REQ_BUILD, 0, 0, 0, 0));
    dir.push_back(make_req(REQ_WRITE, 0, 0, 0, 11'd0));
    dir.push_back(make_req(4'd9, 0, 0, 0, 0));
    dir.push_back(make_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF));
    dir.push_back(make_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    dir.push_back(make_req(REQ_INSERT, 32'h0, 32'hA5A5_A5A5, 0, 0));
    dir.push_back(make_req(REQ_INSERT, 32'h0, 32'h5A5A_5A5A, 0, 0));
    dir.push_back(make_req(REQ_APPEND, 32'd5, 32'd1, 0, 0));
    dir.push_back(make_req(REQ_APPEND, 32'hFFFF_FFFF, 32'd2, 0, 0));
    dir.push_back(make_req(REQ_APPEND, 32'd0, 32'd3, 0, 0));
    dir.push_back(make_req(REQ_BUILD, 0, 0, 0, 0));
    dir.push_back(make_req(REQ_QUERY, 0, 0, 0, 11'd3));
    dir.push_back(make_req(REQ_READ, 0, 0, 0, 11'd2));
    dir.push_back(make_req(REQ_WRITE, 32'd7, 32'hDEAD_BEEF, 0, 11'd1));
    dir.push_back(make_req(REQ_CHANGE, 32'h8000_0000, 32'd9, 11'd2, 0));
    dir.push_back(make_req(REQ_CHANGE, 32'd0, 32'd8, 11'd6, 0));
    dir.push_back(make_req(REQ_REMOVE, 0, 0, 11'd6, 0));
    dir.push_back(make_req(REQ_REMOVE, 0, 0, 11'd2, 0));
    dir.push_back(make_req(REQ_POP, 0, 0, 0, 0));
    dir.push_back(make_req(REQ_QUERY, 0, 0, 0, 11'd6));
    foreach (dir[i]) send(dir[i]);

    for (int i = 0; i < 20; i++) send(rand_req(0));
    // grow to full so the full status and deep sifts are reached
    while (sb.cnt < CAP) send(rand_req(1));
    send(make_req(REQ_INSERT, pick_key(), $urandom, 0, 0));
    send(make_req(REQ_APPEND, pick_key(), $urandom, 0, 0));
    send(make_req(REQ_BUILD, 0, 0, 0, 0));
    for (int i = 0; i < 40; i++) send(rand_req(2));
    req_valid <= 1'b0;
    stim_done = 1'b1;

    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("%0d requests sent, %0d responses checked; peak heap size %0d, %0d full rejects",
             sent, sb.checked, sb.max_cnt, sb.hit_full);
    $display("covered every request type, error paths, equal keys and a long output stall");
    if (sb.fails == 0) begin
      $display("indexed_min_heap_queue_unit_tb OK");
    end else begin
      $display("indexed_min_heap_queue_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
